/* hdl/ognz_pkg.sv */
// Shared types, constants and the permutation table for the octave noise block.
`default_nettype none
package ognz_pkg;

    localparam int unsigned COORD_W     = 32;
    localparam int unsigned VALUE_W     = 17;
    localparam int unsigned COUNT_W     = 4;
    localparam int unsigned CFG_IDX_W   = 4;
    localparam int unsigned CFG_DATA_W  = 17;
    localparam int unsigned QUEUE_DEPTH = 2;
    localparam int unsigned OCT_MAX     = 8;
    localparam int unsigned OCT_W       = $clog2(OCT_MAX);
    localparam logic [VALUE_W-1:0] Q_ONE = VALUE_W'(65536);

    localparam logic [CFG_IDX_W-1:0] REG_OCTAVE_COUNT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_PERSISTENCE  = CFG_IDX_W'(1);

    typedef struct packed {
        logic signed [COORD_W-1:0] x_coord;
        logic signed [COORD_W-1:0] y_coord;
        logic signed [COORD_W-1:0] z_coord;
    } t_point;

    // clamped configuration as the engine sees it
    typedef struct packed {
        logic [OCT_W-1:0]   last_oct;
        logic [VALUE_W-1:0] pers;
    } t_cfg;

    localparam logic [7:0] PERM [0:255] = '{
        8'd151,8'd160,8'd137,8'd91,8'd90,8'd15,8'd131,8'd13,8'd201,8'd95,8'd96,8'd53,
        8'd194,8'd233,8'd7,8'd225,8'd140,8'd36,8'd103,8'd30,8'd69,8'd142,8'd8,8'd99,
        8'd37,8'd240,8'd21,8'd10,8'd23,8'd190,8'd6,8'd148,8'd247,8'd120,8'd234,8'd75,
        8'd0,8'd26,8'd197,8'd62,8'd94,8'd252,8'd219,8'd203,8'd117,8'd35,8'd11,8'd32,
        8'd57,8'd177,8'd33,8'd88,8'd237,8'd149,8'd56,8'd87,8'd174,8'd20,8'd125,8'd136,
        8'd171,8'd168,8'd68,8'd175,8'd74,8'd165,8'd71,8'd134,8'd139,8'd48,8'd27,8'd166,
        8'd77,8'd146,8'd158,8'd231,8'd83,8'd111,8'd229,8'd122,8'd60,8'd211,8'd133,8'd230,
        8'd220,8'd105,8'd92,8'd41,8'd55,8'd46,8'd245,8'd40,8'd244,8'd102,8'd143,8'd54,
        8'd65,8'd25,8'd63,8'd161,8'd1,8'd216,8'd80,8'd73,8'd209,8'd76,8'd132,8'd187,
        8'd208,8'd89,8'd18,8'd169,8'd200,8'd196,8'd135,8'd130,8'd116,8'd188,8'd159,8'd86,
        8'd164,8'd100,8'd109,8'd198,8'd173,8'd186,8'd3,8'd64,8'd52,8'd217,8'd226,8'd250,
        8'd124,8'd123,8'd5,8'd202,8'd38,8'd147,8'd118,8'd126,8'd255,8'd82,8'd85,8'd212,
        8'd207,8'd206,8'd59,8'd227,8'd47,8'd16,8'd58,8'd17,8'd182,8'd189,8'd28,8'd42,
        8'd223,8'd183,8'd170,8'd213,8'd119,8'd248,8'd152,8'd2,8'd44,8'd154,8'd163,8'd70,
        8'd221,8'd153,8'd101,8'd155,8'd167,8'd43,8'd172,8'd9,8'd129,8'd22,8'd39,8'd253,
        8'd19,8'd98,8'd108,8'd110,8'd79,8'd113,8'd224,8'd232,8'd178,8'd185,8'd112,8'd104,
        8'd218,8'd246,8'd97,8'd228,8'd251,8'd34,8'd242,8'd193,8'd238,8'd210,8'd144,8'd12,
        8'd191,8'd179,8'd162,8'd241,8'd81,8'd51,8'd145,8'd235,8'd249,8'd14,8'd239,8'd107,
        8'd49,8'd192,8'd214,8'd31,8'd181,8'd199,8'd106,8'd157,8'd184,8'd84,8'd204,8'd176,
        8'd115,8'd121,8'd50,8'd45,8'd127,8'd4,8'd150,8'd254,8'd138,8'd236,8'd205,8'd93,
        8'd222,8'd114,8'd67,8'd29,8'd24,8'd72,8'd243,8'd141,8'd128,8'd195,8'd78,8'd66,
        8'd215,8'd61,8'd156,8'd180
    };

endpackage
`default_nettype wire

/* hdl/ognz_if.sv */
// Handshake interfaces: point input, result output and register write channel.
`default_nettype none
interface ognz_pt_if;
    logic                                 valid;
    logic                                 ready;
    logic signed [ognz_pkg::COORD_W-1:0]  x_coord;
    logic signed [ognz_pkg::COORD_W-1:0]  y_coord;
    logic signed [ognz_pkg::COORD_W-1:0]  z_coord;
    modport source (output valid, x_coord, y_coord, z_coord, input ready);
    modport sink   (input valid, x_coord, y_coord, z_coord, output ready);
endinterface

interface ognz_res_if;
    logic                          valid;
    logic                          ready;
    logic [ognz_pkg::VALUE_W-1:0]  noise_value;
    modport source (output valid, noise_value, input ready);
    modport sink   (input valid, noise_value, output ready);
endinterface

interface ognz_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [ognz_pkg::CFG_IDX_W-1:0]   index;
    logic [ognz_pkg::CFG_DATA_W-1:0]  data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* hdl/ognz_front.sv */
// Front end: register file, point queue and clamped configuration.
`default_nettype none
module ognz_front #(
    parameter int unsigned QUEUE_DEPTH = ognz_pkg::QUEUE_DEPTH
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    ognz_pt_if.sink             i_pt,
    ognz_cfg_if.sink            i_cfg,
    output ognz_pkg::t_point    o_head,
    output logic                o_head_valid,
    input  wire logic           i_pop,
    output ognz_pkg::t_cfg      o_cfg
);
    import ognz_pkg::*;

    localparam int unsigned PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    t_point            r_q [QUEUE_DEPTH];
    logic [PW-1:0]     r_wp, r_rp;
    logic [CW-1:0]     r_cnt;
    logic [COUNT_W-1:0] r_count;
    logic [VALUE_W-1:0] r_pers;
    logic              push;

    assign i_pt.ready   = (r_cnt != CW'(QUEUE_DEPTH));
    assign push         = i_pt.valid && i_pt.ready;
    assign o_head_valid = (r_cnt != '0);
    assign o_head       = r_q[r_rp];
    assign i_cfg.ready  = 1'b1;

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{x_coord: i_pt.x_coord, y_coord: i_pt.y_coord,
                           z_coord: i_pt.z_coord};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= (r_rp == PW'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            if (push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_W'(1);
            r_pers  <= VALUE_W'(32768);
        end else if (i_cfg.valid && i_cfg.ready) begin
            unique case (i_cfg.index)
                REG_OCTAVE_COUNT: r_count <= i_cfg.data[COUNT_W-1:0];
                REG_PERSISTENCE:  r_pers  <= i_cfg.data[VALUE_W-1:0];
                default: ;
            endcase
        end
    end

    // zero octaves act as one, more than the maximum act as the maximum
    always_comb begin
        if (r_count == '0) begin
            o_cfg.last_oct = '0;
        end else if (r_count > COUNT_W'(OCT_MAX)) begin
            o_cfg.last_oct = OCT_W'(OCT_MAX - 1);
        end else begin
            o_cfg.last_oct = OCT_W'(r_count - 1'b1);
        end
        o_cfg.pers = (r_pers > Q_ONE) ? Q_ONE : r_pers;
    end

endmodule
`default_nettype wire

/* hdl/ognz_back.sv */
// Back end: octave sequencer, shared lerp unit, accumulator and divider.
`default_nettype none
module ognz_back (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire ognz_pkg::t_point    i_head,
    input  wire logic                i_head_valid,
    output logic                     o_pop,
    input  wire ognz_pkg::t_cfg      i_cfg,
    ognz_res_if.source               o_res
);
    import ognz_pkg::*;

    typedef enum logic [9:0] {
        S_IDLE = 10'b0000000001,
        S_P1   = 10'b0000000010,
        S_P2   = 10'b0000000100,
        S_P3   = 10'b0000001000,
        S_GRAD = 10'b0000010000,
        S_LERP = 10'b0000100000,
        S_ACC  = 10'b0001000000,
        S_DIV0 = 10'b0010000000,
        S_DIV  = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    localparam int unsigned DIV_STEPS = VALUE_W;
    localparam int unsigned TOT_W = 36;
    localparam int unsigned WGT_W = 20;

    t_state                r_state;
    t_point                r_pt;
    logic [OCT_W-1:0]      r_oct;
    logic [2:0]            r_lstep;
    logic [4:0]            r_dstep;
    logic [15:0]           r_t2 [3];
    logic [15:0]           r_t3 [3];
    logic [19:0]           r_q  [3];
    logic [16:0]           r_fade [3];
    logic [7:0]            r_px [2];
    logic [7:0]            r_pxy [4];
    logic [7:0]            r_hash [8];
    logic signed [19:0]    r_v [8];
    logic [TOT_W-1:0]      r_total;
    logic [WGT_W-1:0]      r_weight;
    logic [VALUE_W-1:0]    r_amp;
    logic [WGT_W-1:0]      r_rem;
    logic [VALUE_W-1:0]    r_dvd;
    logic [VALUE_W-1:0]    r_quo;
    logic                  r_ov;
    logic [VALUE_W-1:0]    r_res;

    logic [31:0]           sc [3];
    logic [7:0]            ci [3];
    logic [15:0]           fr [3];
    logic [2:0]            ia, ib;
    logic [1:0]            wsel;
    logic signed [20:0]    ldiff;
    logic signed [38:0]    lprod;
    logic signed [19:0]    lres;
    logic signed [20:0]    nsum;
    logic [VALUE_W-1:0]    oval;
    logic [WGT_W:0]        rtry;
    logic                  out_free;

    function automatic logic signed [19:0] grad(input logic [7:0] hash,
                                                input logic signed [16:0] x,
                                                input logic signed [16:0] y,
                                                input logic signed [16:0] z);
        logic [3:0]         h;
        logic signed [19:0] u, v;
        h = hash[3:0];
        u = (h < 4'd8) ? 20'(x) : 20'(y);
        if (h < 4'd4) begin
            v = 20'(y);
        end else if (h == 4'd12 || h == 4'd14) begin
            v = 20'(x);
        end else begin
            v = 20'(z);
        end
        return (h[0] ? -u : u) + (h[1] ? -v : v);
    endfunction

    assign sc[0] = r_pt.x_coord << r_oct;
    assign sc[1] = r_pt.y_coord << r_oct;
    assign sc[2] = r_pt.z_coord << r_oct;

    always_comb begin
        for (int a = 0; a < 3; a++) begin
            ci[a] = sc[a][23:16];
            fr[a] = sc[a][15:0];
        end
    end

    // fixed lerp tree: four along x, two along y, one along z
    always_comb begin
        case (r_lstep)
            3'd0:    begin ia = 3'd0; ib = 3'd1; wsel = 2'd0; end
            3'd1:    begin ia = 3'd2; ib = 3'd3; wsel = 2'd0; end
            3'd2:    begin ia = 3'd4; ib = 3'd5; wsel = 2'd0; end
            3'd3:    begin ia = 3'd6; ib = 3'd7; wsel = 2'd0; end
            3'd4:    begin ia = 3'd0; ib = 3'd2; wsel = 2'd1; end
            3'd5:    begin ia = 3'd4; ib = 3'd6; wsel = 2'd1; end
            default: begin ia = 3'd0; ib = 3'd4; wsel = 2'd2; end
        endcase
        ldiff = 21'(r_v[ib]) - 21'(r_v[ia]);
        lprod = 39'(ldiff) * $signed({22'd0, r_fade[wsel]});
        lres  = r_v[ia] + 20'(lprod >>> 16);
    end

    always_comb begin
        nsum = 21'(r_v[0]) + 21'sd65536;
        if (nsum <= 21'sd0) begin
            oval = '0;
        end else if ((nsum >>> 1) > 21'sd65536) begin
            oval = Q_ONE;
        end else begin
            oval = VALUE_W'(nsum >>> 1);
        end
        rtry = {r_rem, r_dvd[VALUE_W-1]};
    end

    assign out_free    = !r_ov || o_res.ready;
    assign o_pop       = (r_state == S_IDLE) && i_head_valid;
    assign o_res.valid = r_ov;
    assign o_res.noise_value = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
            r_oct   <= '0;
            r_lstep <= '0;
            r_dstep <= '0;
        end else begin
            if (r_state == S_OUT && out_free) begin
                r_ov <= 1'b1;
            end else if (o_res.ready) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_head_valid) begin
                        r_oct   <= '0;
                        r_state <= S_P1;
                    end
                end
                S_P1:   r_state <= S_P2;
                S_P2:   r_state <= S_P3;
                S_P3:   r_state <= S_GRAD;
                S_GRAD: begin
                    r_lstep <= '0;
                    r_state <= S_LERP;
                end
                S_LERP: begin
                    r_lstep <= r_lstep + 1'b1;
                    if (r_lstep == 3'd6) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    if (r_oct == i_cfg.last_oct) begin
                        r_state <= S_DIV0;
                    end else begin
                        r_oct   <= r_oct + 1'b1;
                        r_state <= S_P1;
                    end
                end
                S_DIV0: begin
                    r_dstep <= '0;
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    r_dstep <= r_dstep + 1'b1;
                    if (r_dstep == 5'(DIV_STEPS - 1)) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        logic [31:0] p;
        case (r_state)
            S_IDLE: begin
                r_pt     <= i_head;
                r_total  <= '0;
                r_weight <= '0;
                r_amp    <= Q_ONE;
            end
            S_P1: begin
                for (int a = 0; a < 3; a++) begin
                    p       = 32'(fr[a]) * 32'(fr[a]);
                    r_t2[a] <= p[31:16];
                end
                r_px[0] <= PERM[ci[0]];
                r_px[1] <= PERM[8'(ci[0] + 8'd1)];
            end
            S_P2: begin
                for (int a = 0; a < 3; a++) begin
                    p       = 32'(r_t2[a]) * 32'(fr[a]);
                    r_t3[a] <= p[31:16];
                    r_q[a]  <= 20'(22'sd6 * $signed({6'd0, r_t2[a]})
                                 - 22'sd15 * $signed({6'd0, fr[a]}) + 22'sd655360);
                end
                for (int k = 0; k < 4; k++) begin
                    r_pxy[k] <= PERM[8'(r_px[k % 2] + ci[1] + 8'(k / 2))];
                end
            end
            S_P3: begin
                for (int a = 0; a < 3; a++) begin
                    r_fade[a] <= 17'((36'(r_t3[a]) * 36'(r_q[a])) >> 16);
                end
                for (int k = 0; k < 8; k++) begin
                    r_hash[k] <= PERM[8'(r_pxy[k % 4] + ci[2] + 8'(k / 4))];
                end
            end
            S_GRAD: begin
                for (int k = 0; k < 8; k++) begin
                    r_v[k] <= grad(r_hash[k],
                                   $signed({k % 2 == 1, fr[0]}),
                                   $signed({(k / 2) % 2 == 1, fr[1]}),
                                   $signed({k / 4 == 1, fr[2]}));
                end
            end
            S_LERP: r_v[ia] <= lres;
            S_ACC: begin
                r_total  <= r_total + TOT_W'(34'(oval) * 34'(r_amp));
                r_weight <= r_weight + WGT_W'(r_amp);
                r_amp    <= VALUE_W'((34'(r_amp) * 34'(i_cfg.pers)) >> 16);
            end
            S_DIV0: begin
                r_rem <= WGT_W'(r_total[TOT_W-1:VALUE_W]);
                r_dvd <= r_total[VALUE_W-1:0];
                r_quo <= '0;
            end
            S_DIV: begin
                if (rtry >= (WGT_W+1)'(r_weight)) begin
                    r_rem <= WGT_W'(rtry - (WGT_W+1)'(r_weight));
                    r_quo <= {r_quo[VALUE_W-2:0], 1'b1};
                end else begin
                    r_rem <= WGT_W'(rtry);
                    r_quo <= {r_quo[VALUE_W-2:0], 1'b0};
                end
                r_dvd <= {r_dvd[VALUE_W-2:0], 1'b0};
            end
            S_OUT: begin
                if (out_free) begin
                    r_res <= (r_quo > Q_ONE) ? Q_ONE : r_quo;
                end
            end
            default: ;
        endcase
    end

    // partial remainder must stay below the divisor for the quotient to be right
    a_rem_lt_wgt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_weight))
        else $error("divider remainder not below weight");

    a_oct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_oct <= i_cfg.last_oct))
        else $error("octave index past configured count");

    a_wgt_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV0) |-> (r_weight >= WGT_W'(Q_ONE)))
        else $error("weight sum below one");

    a_out_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT && out_free) |=> r_ov)
        else $error("finished result not presented");

endmodule
`default_nettype wire

/* hdl/octave_gradient_noise_3d.sv */
// Top level of the fractal 3D gradient noise block.
// Usage:
//   i_pt carries one point per beat (x, y, z in signed Q16.16); o_res returns
//   one noise_value beat per point, unsigned Q1.16 in [0, 65536], in order.
//   i_cfg writes octave_count (index 0) and persistence (index 1); write only
//   while no point is in flight. It is always ready.
// Sequence:
//   Each point is taken from the queue head and worked through octave by
//   octave: hash/fade, gradients, seven lerps through one shared multiplier
//   and accumulate; the final weighted mean uses a 17-step restoring
//   divider. The engine finishes one point before it takes the next.
//   A two-entry queue takes points while the engine is busy.
// Reset:
//   Synchronous, active low. Queue and output are emptied, octave_count
//   returns to 1 and persistence to 0.5.
// Stall:
//   The result register holds while o_res.ready is low; the engine waits
//   with the next result, and i_pt.ready drops once the queue is full.
`default_nettype none
module octave_gradient_noise_3d #(
    parameter int unsigned QUEUE_DEPTH = ognz_pkg::QUEUE_DEPTH
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    ognz_pt_if.sink     i_pt,
    ognz_cfg_if.sink    i_cfg,
    ognz_res_if.source  o_res
);
    import ognz_pkg::*;

    t_point  head;
    logic    head_valid;
    logic    pop;
    t_cfg    cfg;

    ognz_front #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_pt         (i_pt),
        .i_cfg        (i_cfg),
        .o_head       (head),
        .o_head_valid (head_valid),
        .i_pop        (pop),
        .o_cfg        (cfg)
    );

    ognz_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_head_valid (head_valid),
        .o_pop        (pop),
        .i_cfg        (cfg),
        .o_res        (o_res)
    );

endmodule
`default_nettype wire

/* dv/octave_gradient_noise_3d_test.sv */
// Self-checking testbench for the fractal 3D gradient noise block.
`default_nettype none
module octave_gradient_noise_3d_test;
    import ognz_pkg::*;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    ognz_pt_if  pt_bus ();
    ognz_res_if res_bus ();
    ognz_cfg_if cfg_bus ();

    octave_gradient_noise_3d dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_pt    (pt_bus.sink),
        .i_cfg   (cfg_bus.sink),
        .o_res   (res_bus.source)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    typedef struct {
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        int          want;   // -1: taken from the predictor
    } t_row;

    // predictor state
    logic [3:0]          model_count = 4'd1;
    logic [16:0]         model_pers  = 17'd32768;
    logic [VALUE_W-1:0]  noise_fifo [$];
    int                  err_count = 0;
    int                  cycle_count = 0;
    bit                  hold_long = 1'b0;
    bit                  stim_done = 1'b0;

    function automatic int unsigned perm_lut(int unsigned i);
        return PERM[i & 255];
    endfunction

    function automatic longint floor_q16(longint a, longint b);
        longint p;
        p = a * b;
        if (p >= 0) return p / 65536;
        return -((-p + 65535) / 65536);
    endfunction

    function automatic longint fade_curve(longint t);
        longint t2, t3, q;
        t2 = (t * t) >>> 16;
        t3 = (t2 * t) >>> 16;
        q  = 6 * t2 - 15 * t + 655360;
        return (t3 * q) >>> 16;
    endfunction

    function automatic longint blend(longint a, longint b, longint w);
        return a + floor_q16(b - a, w);
    endfunction

    function automatic longint grad_dot(int unsigned hash, longint x, longint y, longint z);
        int unsigned h;
        longint u, v;
        h = hash & 15;
        u = (h < 8) ? x : y;
        if (h < 4) v = y;
        else if (h == 12 || h == 14) v = x;
        else v = z;
        return ((h & 1) ? -u : u) + ((h & 2) ? -v : v);
    endfunction

    function automatic int unsigned corner_hash(int unsigned xi, int unsigned yi,
                                                int unsigned zi);
        return perm_lut(perm_lut(perm_lut(xi) + yi) + zi);
    endfunction

    function automatic longint octave_noise(logic [31:0] cx, logic [31:0] cy,
                                            logic [31:0] cz);
        int unsigned xi, yi, zi;
        longint x0, y0, z0, x1, y1, z1, u, v, w, a, b, s1, s2, n;
        xi = cx[23:16]; yi = cy[23:16]; zi = cz[23:16];
        x0 = cx[15:0];  y0 = cy[15:0];  z0 = cz[15:0];
        x1 = x0 - 65536; y1 = y0 - 65536; z1 = z0 - 65536;
        u = fade_curve(x0); v = fade_curve(y0); w = fade_curve(z0);
        a = blend(grad_dot(corner_hash(xi, yi, zi), x0, y0, z0),
                  grad_dot(corner_hash(xi+1, yi, zi), x1, y0, z0), u);
        b = blend(grad_dot(corner_hash(xi, yi+1, zi), x0, y1, z0),
                  grad_dot(corner_hash(xi+1, yi+1, zi), x1, y1, z0), u);
        s1 = blend(a, b, v);
        a = blend(grad_dot(corner_hash(xi, yi, zi+1), x0, y0, z1),
                  grad_dot(corner_hash(xi+1, yi, zi+1), x1, y0, z1), u);
        b = blend(grad_dot(corner_hash(xi, yi+1, zi+1), x0, y1, z1),
                  grad_dot(corner_hash(xi+1, yi+1, zi+1), x1, y1, z1), u);
        s2 = blend(a, b, v);
        n = blend(s1, s2, w) + 65536;
        if (n <= 0) return 0;
        n = n / 2;
        return (n > 65536) ? 65536 : n;
    endfunction

    function automatic logic [VALUE_W-1:0] fractal_noise(logic [31:0] x, logic [31:0] y,
                                                         logic [31:0] z);
        int unsigned cnt;
        longint amp, pers, total, weight, res;
        cnt  = (model_count < 1) ? 1 : (model_count > 8) ? 8 : model_count;
        pers = (model_pers > 65536) ? 65536 : model_pers;
        amp = 65536; total = 0; weight = 0;
        for (int i = 0; i < cnt; i++) begin
            total  += octave_noise(x << i, y << i, z << i) * amp;
            weight += amp;
            amp = (amp * pers) >>> 16;
        end
        res = total / weight;
        if (res > 65536) res = 65536;
        return VALUE_W'(res);
    endfunction

    task automatic report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d at cycle %0d", what, got, want, cycle_count);
        err_count++;
    endtask

    initial begin
        pt_bus.valid = 1'b0;
        pt_bus.x_coord = '0; pt_bus.y_coord = '0; pt_bus.z_coord = '0;
        cfg_bus.valid = 1'b0; cfg_bus.index = '0; cfg_bus.data = '0;
        res_bus.ready = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 2000000) begin
            $display("[octave_gradient_noise_3d] ERROR");
            $finish;
        end
    end

    // result side: check and random stall
    always @(posedge i_clk) begin
        if (i_rst_n && res_bus.valid && res_bus.ready) begin
            if (noise_fifo.size() == 0)
                report("unexpected beat", res_bus.noise_value, -1);
            else begin
                logic [VALUE_W-1:0] want;
                want = noise_fifo.pop_front();
                if (res_bus.noise_value !== want)
                    report("noise_value", res_bus.noise_value, want);
            end
        end
    end

    initial begin
        int gap;
        @(posedge i_rst_n);
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                res_bus.ready = 1'b0;
                repeat (400) @(negedge i_clk);
                hold_long = 1'b0;
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16);
            res_bus.ready = 1'b0;
            repeat (gap) @(negedge i_clk);
            res_bus.ready = 1'b1;
            do @(posedge i_clk); while (!res_bus.valid);
        end
    end

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [16:0] val);
        cfg_bus.index = idx;
        cfg_bus.data  = val;
        cfg_bus.valid = 1'b1;
        do @(posedge i_clk); while (!cfg_bus.ready);
        if (idx == REG_OCTAVE_COUNT) model_count = val[3:0];
        else if (idx == REG_PERSISTENCE) model_pers = val;
        @(negedge i_clk);
        cfg_bus.valid = 1'b0;
    endtask

    task automatic drain();
        while (noise_fifo.size() != 0) @(negedge i_clk);
        repeat (140) @(negedge i_clk);
    endtask

    task automatic send_point(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              int want, bit idle);
        int gap;
        gap = idle ? (($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 16)) : 0;
        pt_bus.valid = 1'b0;
        repeat (gap) @(negedge i_clk);
        pt_bus.x_coord = x; pt_bus.y_coord = y; pt_bus.z_coord = z;
        pt_bus.valid = 1'b1;
        do @(posedge i_clk); while (!pt_bus.ready);
        noise_fifo.insert(noise_fifo.size(),
                          (want >= 0) ? VALUE_W'(want) : fractal_noise(x, y, z));
        @(negedge i_clk);
        pt_bus.valid = 1'b0;
    endtask

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 3))
            0: return $urandom();
            1: return 32'($signed($urandom_range(0, 2000000)) - 1000000);
            2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
            default: return {16'($urandom()), 16'h0000};
        endcase
    endfunction

    // lattice points give zero gradient sum: noise 0.5 in every octave
    t_row dir_rows [] = '{
        '{32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 32768},
        '{32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32768},
        '{32'hffff_0000, 32'hfffe_0000, 32'h8000_0000, 32768},
        '{32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, -1},
        '{32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32768},
        '{32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, -1},
        '{32'h0000_8000, 32'h0000_8000, 32'h0000_8000, -1},
        '{32'h0000_ffff, 32'h0000_0001, 32'h8000_8000, -1},
        '{32'h5555_5555, 32'haaaa_aaaa, 32'h0f0f_0f0f, -1},
        '{32'haaaa_aaaa, 32'h5555_5555, 32'hf0f0_f0f0, -1},
        '{32'h0123_4567, 32'h89ab_cdef, 32'hfedc_ba98, -1},
        '{32'hffff_8000, 32'h0000_4000, 32'h00ff_c000, -1}
    };

    logic [3:0]  count_set [] = '{4'd8, 4'd0, 4'd15, 4'd3, 4'd1, 4'd5};
    logic [16:0] pers_set  [] = '{17'd65536, 17'd0, 17'h1ffff, 17'd45000, 17'd32768,
                                  17'd12345};

    initial begin
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (dir_rows[k])
            send_point(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].want, 1'b1);
        drain();
        write_reg(REG_OCTAVE_COUNT, 17'd8);
        write_reg(REG_PERSISTENCE, 17'd65536);
        foreach (dir_rows[k])
            send_point(dir_rows[k].x, dir_rows[k].y, dir_rows[k].z, dir_rows[k].want, 1'b1);

        foreach (count_set[p]) begin
            drain();
            write_reg(REG_OCTAVE_COUNT, count_set[p]);
            write_reg(REG_PERSISTENCE, pers_set[p]);
            for (int k = 0; k < 220; k++) begin
                if (p == 1 && k == 20) hold_long = 1'b1;
                // back-to-back during the long hold so the queue fills
                send_point(rand_coord(), rand_coord(), rand_coord(), -1,
                           !(p == 1 && k >= 20 && k < 40));
            end
        end
        drain();
        if (err_count == 0)
            $display("[octave_gradient_noise_3d] OK");
        else
            $display("[octave_gradient_noise_3d] ERROR");
        $finish;
    end
endmodule
`default_nettype wire

/* filelist.f */
hdl/ognz_pkg.sv
hdl/ognz_if.sv
hdl/ognz_front.sv
hdl/ognz_back.sv
hdl/octave_gradient_noise_3d.sv
dv/octave_gradient_noise_3d_test.sv
